// ===== rtl/core/uniform_grid_linear_resampler_top_assert.svh =====
// Assertion macros for the uniform grid linear resampler
`ifndef UNIFORM_GRID_LINEAR_RESAMPLER_TOP_ASSERT_SVH
`define UNIFORM_GRID_LINEAR_RESAMPLER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define UGLR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define UGLR_ASSERT_NEXT(lbl, clk, rstn, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) else $error(msg);
`else
`define UGLR_ASSERT(lbl, clk, rstn, prop, msg)
`define UGLR_ASSERT_NEXT(lbl, clk, rstn, cond, expr, msg)
`endif
`endif

// ===== rtl/core/uglr_pkg.sv =====
package uglr_pkg;

    localparam int SAMPLE_DEPTH_DEF = 1024;
    localparam int GRID_DEPTH_DEF   = 1024;
    localparam int XW               = 31;
    localparam int YW               = 32;
    localparam int DYW              = 33;

    localparam logic [30:0] GRID_STEP_RST  = 31'd65536;
    localparam logic [10:0] GRID_COUNT_RST = 11'd1024;

    localparam logic [1:0] REG_GRID_MODE  = 2'd0;
    localparam logic [1:0] REG_GRID_STEP  = 2'd1;
    localparam logic [1:0] REG_GRID_COUNT = 2'd2;
    localparam logic [1:0] REG_LIFT       = 2'd3;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic MODE_STEP  = 1'b0;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FEW   = 2'd2;
    localparam logic [1:0] STAT_OVF   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_ORG,
        ST_LASTX,
        ST_SPAN,
        ST_GDIV,
        ST_SRCH,
        ST_SCMP,
        ST_P0,
        ST_P1,
        ST_P2,
        ST_MDIV,
        ST_WR,
        ST_LRD,
        ST_LWR
    } uglr_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV,
        MD_DONE
    } uglr_md_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [34:0] hi;
        logic signed [34:0] lo;
        hi = 35'sh0_7FFF_FFFF;
        lo = -35'sh0_8000_0000;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

// ===== rtl/core/uniform_grid_linear_resampler_top.sv =====
// Loads are accepted while the block is idle; a read moves it to a read state that puts
// the result in the output registers once they are free, the block stalling while a
// result waits, so a new read is taken only after the last result has been issued.
// After the final sample one shared multiply-divide unit sizes the grid, then interpolates
// each point after its bracket search; lifting adds a pass that rewrites every point.
// Reset (synchronous, active low) clears control state and counts; stores keep.
`include "uniform_grid_linear_resampler_top_assert.svh"
module uniform_grid_linear_resampler_top #(
    parameter int SAMPLE_DEPTH = uglr_pkg::SAMPLE_DEPTH_DEF,
    parameter int GRID_DEPTH   = uglr_pkg::GRID_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_action,
    input  logic [30:0]         s_sample_x,
    input  logic signed [31:0]  s_sample_y,
    input  logic                s_final_sample,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [30:0]         m_grid_x,
    output logic signed [31:0]  m_resampled_y,
    output logic                m_last_point,
    output logic [1:0]          m_status
);
    import uglr_pkg::*;

    localparam int SCW = $clog2(SAMPLE_DEPTH + 1);
    localparam int SAW = $clog2(SAMPLE_DEPTH);
    localparam int GCW = $clog2(GRID_DEPTH + 1);
    localparam int GAW = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
    localparam int GXW = GCW + XW;
    localparam int PW  = DYW + GXW;

    // configuration
    logic              mode_reg;
    logic [30:0]       step_cfg_reg;
    logic [10:0]       count_cfg_reg;
    logic              lift_reg;

    // stores
    logic [30:0]       xmem [SAMPLE_DEPTH];
    logic [31:0]       ymem [SAMPLE_DEPTH];
    logic [31:0]       rmem [GRID_DEPTH];
    logic [30:0]       x_rd_reg;
    logic signed [31:0] y_rd_reg;
    logic signed [31:0] r_rd_reg;

    uglr_state_t       state_reg, state_next;
    logic [SCW-1:0]    stotal_reg;
    logic [SCW-1:0]    n_reg;
    logic [GCW-1:0]    rtotal_reg;
    logic [GCW-1:0]    rp_reg;
    logic [1:0]        err_reg;
    logic [30:0]       step_reg;
    logic [30:0]       origin_reg;
    logic [30:0]       rd_gx_reg;
    logic [GCW-1:0]    count_reg;
    logic [GCW-1:0]    i_reg;
    logic [GXW-1:0]    gx_reg;
    logic [SCW-1:0]    j_reg;
    logic [SCW-1:0]    k_reg;
    logic [30:0]       x0_reg;
    logic signed [31:0] y0_reg;
    logic              neg_reg;
    logic signed [31:0] res_reg;
    logic signed [31:0] minv_reg;
    logic              hit_reg;

    logic              m_valid_reg;
    logic [30:0]       gx_out_reg;
    logic signed [31:0] y_out_reg;
    logic              last_reg;
    logic [1:0]        status_reg;

    // handshake and load path
    logic              accept, load, store_ok, final_load, out_free;
    logic [SCW-1:0]    n_after;
    logic [SCW-1:0]    n_m1;
    logic [SCW-1:0]    k_p1;
    logic [GCW-1:0]    i_p1;

    // sequencer controls
    logic [SAW-1:0]    s_raddr;
    logic [GAW-1:0]    r_raddr;
    logic              r_we;
    logic [GAW-1:0]    r_waddr;
    logic signed [31:0] r_wdata;
    logic              md_start;
    logic [DYW-1:0]    md_a;
    logic [GXW-1:0]    md_b;
    logic [30:0]       md_d;
    logic              md_done;
    logic [PW-1:0]     md_q;

    // arithmetic
    logic [30:0]       span;
    logic [30:0]       step_eff;
    logic signed [31:0] dx;
    logic signed [32:0] dy;
    logic signed [GXW:0] off;
    logic [31:0]       adx_w;
    logic [32:0]       ady_w;
    logic [GXW:0]      aoff_w;
    logic [33:0]       q_sat;
    logic signed [34:0] y0_ext;
    logic signed [34:0] interp_sum;
    logic signed [31:0] interp_y;
    logic signed [31:0] min_new;
    logic signed [31:0] lifted;
    logic              grid_ovf;
    logic              cnt_ovf;
    logic              lift_now;

    assign pready  = 1'b1;
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign load    = accept && (s_action == ACT_LOAD);
    assign store_ok   = stotal_reg < SCW'(SAMPLE_DEPTH);
    assign n_after    = stotal_reg + (store_ok ? SCW'(1) : SCW'(0));
    assign final_load = load && s_final_sample;
    assign out_free   = !m_valid_reg || m_ready;
    assign n_m1 = n_reg - SCW'(1);
    assign k_p1 = k_reg + SCW'(1);
    assign i_p1 = i_reg + GCW'(1);

    assign m_valid       = m_valid_reg;
    assign m_grid_x      = gx_out_reg;
    assign m_resampled_y = y_out_reg;
    assign m_last_point  = last_reg;
    assign m_status      = status_reg;

    // configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_STEP;
            step_cfg_reg  <= GRID_STEP_RST;
            count_cfg_reg <= GRID_COUNT_RST;
            lift_reg      <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_GRID_MODE:  mode_reg      <= pwdata[0];
                REG_GRID_STEP:  step_cfg_reg  <= pwdata[30:0];
                REG_GRID_COUNT: count_cfg_reg <= pwdata[10:0];
                REG_LIFT:       lift_reg      <= pwdata[0];
                default:        lift_reg      <= lift_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_GRID_MODE:  prdata = {31'd0, mode_reg};
            REG_GRID_STEP:  prdata = {1'b0, step_cfg_reg};
            REG_GRID_COUNT: prdata = {21'd0, count_cfg_reg};
            REG_LIFT:       prdata = {31'd0, lift_reg};
            default:        prdata = '0;
        endcase
    end

    // arithmetic shared by the sequencer states
    always_comb begin
        span     = (x_rd_reg >= origin_reg) ? x_rd_reg - origin_reg : '0;
        step_eff = (step_cfg_reg == '0) ? 31'd1 : step_cfg_reg;
        dx       = $signed({1'b0, x_rd_reg}) - $signed({1'b0, x0_reg});
        dy       = $signed({y_rd_reg[31], y_rd_reg}) - $signed({y0_reg[31], y0_reg});
        off      = $signed({1'b0, gx_reg}) - $signed((GXW + 1)'({1'b0, x0_reg}));
        adx_w    = dx[31] ? 32'(-dx) : 32'(dx);
        ady_w    = dy[32] ? 33'(-dy) : 33'(dy);
        aoff_w   = off[GXW] ? (GXW + 1)'(-off) : (GXW + 1)'(off);
        // anything at or above 2^33 saturates whatever y0 is
        q_sat    = (|md_q[PW-1:33]) ? {1'b1, 33'd0} : {1'b0, md_q[32:0]};
        y0_ext   = 35'(y0_reg);
        interp_sum = neg_reg ? y0_ext - $signed({1'b0, q_sat})
                             : y0_ext + $signed({1'b0, q_sat});
        interp_y = sat32(interp_sum);
        min_new  = (res_reg < minv_reg) ? res_reg : minv_reg;
        lifted   = sat32(35'(r_rd_reg) - 35'(minv_reg));
        grid_ovf = 32'(count_cfg_reg) > 32'(GRID_DEPTH);
        cnt_ovf  = md_q >= PW'(GRID_DEPTH);
        lift_now = lift_reg && min_new[31];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_action == ACT_READ) begin
                    state_next = ST_READ;
                end else if (final_load && n_after >= SCW'(2)) begin
                    state_next = ST_ORG;
                end
            end
            ST_READ:  if (out_free) state_next = ST_IDLE;
            ST_ORG:   state_next = ST_LASTX;
            ST_LASTX: state_next = ST_SPAN;
            ST_SPAN: begin
                if (mode_reg == MODE_STEP) begin
                    state_next = ST_GDIV;
                end else if (count_cfg_reg == '0 || grid_ovf) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_GDIV;
                end
            end
            ST_GDIV: begin
                if (md_done) begin
                    if (mode_reg == MODE_STEP && cnt_ovf) state_next = ST_IDLE;
                    else state_next = ST_SRCH;
                end
            end
            ST_SRCH: state_next = (j_reg >= n_reg) ? ST_P0 : ST_SCMP;
            ST_SCMP: state_next = (GXW'(x_rd_reg) >= gx_reg) ? ST_P0 : ST_SRCH;
            ST_P0:   state_next = ST_P1;
            ST_P1:   state_next = ST_P2;
            ST_P2:   state_next = (dx == '0) ? ST_WR : ST_MDIV;
            ST_MDIV: if (md_done) state_next = ST_WR;
            ST_WR: begin
                if (i_p1 != count_reg) state_next = ST_SRCH;
                else if (lift_now) state_next = ST_LRD;
                else state_next = ST_IDLE;
            end
            ST_LRD:  state_next = ST_LWR;
            ST_LWR:  state_next = (i_p1 == count_reg) ? ST_IDLE : ST_LRD;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_raddr  = '0;
        r_raddr  = rp_reg[GAW-1:0];
        r_we     = 1'b0;
        r_waddr  = i_reg[GAW-1:0];
        r_wdata  = res_reg;
        md_start = 1'b0;
        md_a     = DYW'(span);
        md_b     = GXW'(1);
        md_d     = (mode_reg == MODE_STEP) ? step_eff : 31'(count_cfg_reg);
        case (state_reg)
            ST_LASTX: s_raddr = n_m1[SAW-1:0];
            ST_SPAN: begin
                md_start = (mode_reg == MODE_STEP) || (count_cfg_reg != '0 && !grid_ovf);
            end
            ST_SRCH: s_raddr = j_reg[SAW-1:0];
            ST_P0:   s_raddr = k_reg[SAW-1:0];
            ST_P1:   s_raddr = k_p1[SAW-1:0];
            ST_P2: begin
                md_start = (dx != '0);
                md_a     = ady_w;
                md_b     = aoff_w[GXW-1:0];
                md_d     = adx_w[30:0];
            end
            ST_WR:   r_we = 1'b1;
            ST_LRD:  r_raddr = i_reg[GAW-1:0];
            ST_LWR: begin
                r_we    = 1'b1;
                r_wdata = lifted;
            end
            default: s_raddr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load && store_ok) begin
            xmem[stotal_reg[SAW-1:0]] <= s_sample_x;
            ymem[stotal_reg[SAW-1:0]] <= s_sample_y;
        end
        x_rd_reg <= xmem[s_raddr];
        y_rd_reg <= ymem[s_raddr];
    end

    always_ff @(posedge aclk) begin
        if (r_we) rmem[r_waddr] <= r_wdata;
        r_rd_reg <= rmem[r_raddr];
    end

    uglr_muldiv #(
        .AW (DYW),
        .BW (GXW),
        .DW (XW)
    ) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (md_start),
        .a       (md_a),
        .b       (md_b),
        .d       (md_d),
        .done    (md_done),
        .q       (md_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            stotal_reg  <= '0;
            rtotal_reg  <= '0;
            rp_reg      <= '0;
            err_reg     <= STAT_OK;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // a read state reloads the output register itself
            if (m_valid_reg && m_ready && state_reg != ST_READ) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (accept && s_action == ACT_READ) begin
                        hit_reg <= rp_reg < rtotal_reg;
                    end
                    if (load && !s_final_sample) stotal_reg <= n_after;
                    if (final_load) begin
                        // a final mark closes the set and drops the old grid
                        stotal_reg <= '0;
                        n_reg      <= n_after;
                        rtotal_reg <= '0;
                        rp_reg     <= '0;
                        err_reg    <= (n_after < SCW'(2)) ? STAT_FEW : STAT_OK;
                    end
                end
                ST_READ: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        if (hit_reg) begin
                            gx_out_reg <= rd_gx_reg;
                            y_out_reg  <= r_rd_reg;
                            last_reg   <= (rp_reg + GCW'(1)) == rtotal_reg;
                            status_reg <= STAT_OK;
                            rp_reg     <= rp_reg + GCW'(1);
                            rd_gx_reg  <= rd_gx_reg + step_reg;
                        end else begin
                            gx_out_reg <= '0;
                            y_out_reg  <= '0;
                            last_reg   <= 1'b0;
                            status_reg <= (err_reg != STAT_OK) ? err_reg : STAT_EMPTY;
                        end
                    end
                end
                ST_LASTX: begin
                    origin_reg <= x_rd_reg;
                    rd_gx_reg  <= x_rd_reg;
                end
                ST_SPAN: begin
                    if (mode_reg == MODE_STEP) begin
                        step_reg <= step_eff;
                    end else if (count_cfg_reg == '0) begin
                        step_reg <= '0;
                    end else if (grid_ovf) begin
                        err_reg <= STAT_OVF;
                    end else begin
                        count_reg <= GCW'(count_cfg_reg);
                    end
                end
                ST_GDIV: begin
                    if (md_done) begin
                        if (mode_reg == MODE_STEP) begin
                            if (cnt_ovf) err_reg <= STAT_OVF;
                            else count_reg <= GCW'(md_q) + GCW'(1);
                        end else begin
                            step_reg <= md_q[30:0];
                        end
                        i_reg    <= '0;
                        gx_reg   <= GXW'(origin_reg);
                        j_reg    <= SCW'(1);
                        minv_reg <= '0;
                    end
                end
                ST_SRCH: begin
                    // clamp to the last pair when no sample reaches the grid x
                    if (j_reg >= n_reg) k_reg <= n_reg - SCW'(2);
                end
                ST_SCMP: begin
                    if (GXW'(x_rd_reg) >= gx_reg) k_reg <= j_reg - SCW'(1);
                    else j_reg <= j_reg + SCW'(1);
                end
                ST_P1: begin
                    x0_reg <= x_rd_reg;
                    y0_reg <= y_rd_reg;
                end
                ST_P2: begin
                    neg_reg <= dx[31] ^ dy[32] ^ off[GXW];
                    if (dx == '0) res_reg <= y0_reg;
                end
                ST_MDIV: begin
                    if (md_done) res_reg <= interp_y;
                end
                ST_WR: begin
                    minv_reg <= min_new;
                    if (i_p1 != count_reg) begin
                        i_reg  <= i_p1;
                        gx_reg <= gx_reg + GXW'(step_reg);
                    end else if (lift_now) begin
                        i_reg <= '0;
                    end else begin
                        rtotal_reg <= count_reg;
                    end
                end
                ST_LWR: begin
                    if (i_p1 == count_reg) rtotal_reg <= count_reg;
                    else i_reg <= i_p1;
                end
                default: begin
                    // address phases only
                end
            endcase
        end
    end

    `UGLR_ASSERT(a_rp_in_range, aclk, aresetn, rp_reg <= rtotal_reg, "read position past grid")
    `UGLR_ASSERT(a_grid_fits, aclk, aresetn, rtotal_reg <= GCW'(GRID_DEPTH), "grid exceeds store")
    `UGLR_ASSERT(a_md_expected, aclk, aresetn, md_done |-> (state_reg == ST_GDIV || state_reg == ST_MDIV), "unexpected divide completion")
    `UGLR_ASSERT_NEXT(a_read_out, aclk, aresetn, state_reg == ST_READ && out_free, m_valid_reg && state_reg == ST_IDLE, "read result not issued")

endmodule

// ===== rtl/core/uglr_muldiv.sv =====
module uglr_muldiv #(
    parameter int AW = 33,
    parameter int BW = 42,
    parameter int DW = 31
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [AW-1:0]       a,
    input  logic [BW-1:0]       b,
    input  logic [DW-1:0]       d,
    output logic                done,
    output logic [AW+BW-1:0]    q
);
    import uglr_pkg::*;

    localparam int PW = AW + BW;
    localparam int CW = $clog2(PW + 1);

    uglr_md_state_t    state_reg, state_next;
    logic [CW-1:0]     cnt_reg;
    logic [PW-1:0]     acc_reg;
    logic [PW-1:0]     mcand_reg;
    logic [BW-1:0]     mplier_reg;
    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     d_reg;
    logic [DW:0]       rem_sh;
    logic [DW:0]       rem_diff;
    logic              ge;

    assign rem_sh   = {rem_reg, acc_reg[PW-1]};
    assign ge       = rem_sh >= {1'b0, d_reg};
    assign rem_diff = rem_sh - {1'b0, d_reg};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            MD_IDLE: begin
                if (start) state_next = MD_MUL;
            end
            MD_MUL: begin
                if (cnt_reg == CW'(BW - 1)) state_next = MD_DIV;
            end
            MD_DIV: begin
                if (cnt_reg == CW'(PW - 1)) state_next = MD_DONE;
            end
            MD_DONE: state_next = MD_IDLE;
            default: state_next = MD_IDLE;
        endcase
    end

    always_comb begin
        done = (state_reg == MD_DONE);
        q    = acc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                MD_IDLE: begin
                    cnt_reg    <= '0;
                    acc_reg    <= '0;
                    mcand_reg  <= PW'(a);
                    mplier_reg <= b;
                    d_reg      <= d;
                    rem_reg    <= '0;
                end
                MD_MUL: begin
                    // shift-add, one multiplier bit a cycle
                    if (mplier_reg[0]) acc_reg <= acc_reg + mcand_reg;
                    mcand_reg  <= {mcand_reg[PW-2:0], 1'b0};
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= (cnt_reg == CW'(BW - 1)) ? '0 : cnt_reg + CW'(1);
                end
                MD_DIV: begin
                    // restoring division, quotient shifts in behind the dividend
                    acc_reg <= {acc_reg[PW-2:0], ge};
                    rem_reg <= ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
                    cnt_reg <= cnt_reg + CW'(1);
                end
                MD_DONE: cnt_reg <= '0;
                default: cnt_reg <= '0;
            endcase
        end
    end

endmodule
